@@ rtl/g2l_pkg.sv @@
`timescale 1ns / 1ps

package g2l_pkg;

    localparam int unsigned ROM_WORDS = 101;
    localparam int unsigned ROM_AW    = 7;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned DAY_W     = 16;   // day offset from the lunar base date
    localparam int unsigned SUM_W     = 17;   // day count from Jan 1 of the base year
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [YEAR_W-1:0] BASE_YEAR      = 12'd1999;
    localparam logic [YEAR_W-1:0] LAST_ROM_YEAR  = 12'd2100;
    localparam logic [YEAR_W-1:0] LEAP_ANCHOR    = 12'd1997;
    localparam logic [SUM_W-1:0]  BASE_DAY       = 17'd46;  // Feb 16 of the base year
    localparam logic [SUM_W-1:0]  DAYS_PER_YEAR  = 17'd365;
    localparam logic [8:0]        LUNAR_YEAR_MIN = 9'd348;  // twelve 29-day months

    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_YEAR = 1'b0,
        CFG_LAST_YEAR  = 1'b1
    } t_cfg_idx;

    // Word layout: [16] leap month long, [15:4] months 1..12 long, [3:0] leap month number
    localparam logic [16:0] LUNAR_ROM [0:ROM_WORDS-1] = '{
        17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552, 17'h056a0, 17'h0abb7,
        17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0, 17'h0bca4, 17'h0ad50, 17'h055d9,
        17'h04ba0, 17'h0a5b0, 17'h15176, 17'h05270, 17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50,
        17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4f0, 17'h05260, 17'h0ea65, 17'h0d520, 17'h0daa0,
        17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520,
        17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
        17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970, 17'h064b0,
        17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0, 17'h092e0, 17'h0d2e3, 17'h0c960,
        17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0, 17'h0a6d0, 17'h055d4, 17'h092d0,
        17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0,
        17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60,
        17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0,
        17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252
    };

    typedef struct packed {
        logic             ok;
        logic [DAY_W-1:0] days;
    } t_item;

    function automatic logic [16:0] lunar_word(input logic [ROM_AW-1:0] idx);
        if (idx < ROM_AW'(ROM_WORDS)) begin
            return LUNAR_ROM[idx];
        end
        return 17'd0;
    endfunction

    function automatic logic [4:0] month_len(input logic [16:0] word, input logic [3:0] m);
        logic [4:0] bit_idx;
        bit_idx = 5'd16 - {1'b0, m};
        return word[bit_idx] ? 5'd30 : 5'd29;
    endfunction

    function automatic logic [4:0] leap_len(input logic [16:0] word);
        return word[16] ? 5'd30 : 5'd29;
    endfunction

    function automatic logic [8:0] year_len(input logic [16:0] word);
        logic [8:0] d;
        d = LUNAR_YEAR_MIN;
        for (int i = 4; i < 16; i++) begin
            d = d + 9'(word[i]);
        end
        if (word[3:0] != 4'd0) begin
            d = d + 9'(leap_len(word));
        end
        return d;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd1:    return 9'd0;
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] solar_len(input logic leap, input logic [3:0] m);
        case (m)
            4'd2:                           return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:        return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                   return 5'd31;
            default:                        return 5'd0;
        endcase
    endfunction

endpackage

@@ rtl/g2l_front.sv @@
`timescale 1ns / 1ps

module g2l_front (
    input  logic [11:0]   i_first_year,
    input  logic [11:0]   i_last_year,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [11:0]   i_greg_year,
    input  logic [3:0]    i_greg_month,
    input  logic [4:0]    i_greg_day,
    input  logic          i_full,
    output logic          o_push,
    output g2l_pkg::t_item o_item
);
    import g2l_pkg::*;

    logic             year_ok;
    logic             date_ok;
    logic             leap;
    logic [6:0]       year_ofs;
    logic [YEAR_W-1:0] leap_span;
    logic [SUM_W-1:0] day_sum;

    // Years after 2100 would run past the table end anyway, so they are dropped here.
    assign year_ok = (i_greg_year >= i_first_year) && (i_greg_year <= i_last_year) &&
                     (i_greg_year >= BASE_YEAR) && (i_greg_year <= LAST_ROM_YEAR);
    // within the accepted span only 2100 breaks the four-year rule
    assign leap    = (i_greg_year[1:0] == 2'd0) && (i_greg_year != LAST_ROM_YEAR);
    assign date_ok = (i_greg_month >= 4'd1) && (i_greg_month <= 4'd12) &&
                     (i_greg_day >= 5'd1) &&
                     (i_greg_day <= solar_len(leap, i_greg_month));

    assign year_ofs  = 7'(i_greg_year - BASE_YEAR);
    assign leap_span = (i_greg_year - LEAP_ANCHOR) >> 2;   // leap years in [base, year)

    assign day_sum = SUM_W'(year_ofs) * DAYS_PER_YEAR
                   + SUM_W'(leap_span)
                   + SUM_W'(month_start(i_greg_month))
                   + SUM_W'(leap && (i_greg_month > 4'd2))
                   + SUM_W'(i_greg_day) - SUM_W'(1);

    assign o_in_ready  = !i_full;
    assign o_push      = i_in_valid && !i_full;
    assign o_item.ok   = year_ok && date_ok && (day_sum >= BASE_DAY);
    assign o_item.days = DAY_W'(day_sum - BASE_DAY);

endmodule

@@ rtl/g2l_queue.sv @@
`timescale 1ns / 1ps

module g2l_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  g2l_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output g2l_pkg::t_item o_item
);
    import g2l_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_item                r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]        r_wp, r_rp;
    logic [PW:0]          r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

@@ rtl/g2l_back.sv @@
`timescale 1ns / 1ps

module g2l_back #(
    parameter int unsigned TABLE_YEARS = 101
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  g2l_pkg::t_item i_q_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_ok,
    output logic [11:0]    o_lun_year,
    output logic [3:0]     o_lun_month,
    output logic [4:0]     o_lunar_day,
    output logic           o_is_leap_month
);
    import g2l_pkg::*;

    localparam int unsigned KW = $clog2(TABLE_YEARS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_YEAR  = 4'b0010,
        S_MONTH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [DAY_W-1:0] r_rem, n_rem;
    logic [KW-1:0]    r_k, n_k;
    logic [3:0]       r_m, n_m;
    logic             r_in_leap, n_in_leap;
    logic [16:0]      r_word, n_word;
    logic             r_res_ok, n_res_ok;
    logic [11:0]      r_res_year, n_res_year;
    logic [3:0]       r_res_month, n_res_month;
    logic [4:0]       r_res_day, n_res_day;
    logic             r_res_leap, n_res_leap;
    logic             r_out_valid;
    logic             out_free;

    logic [16:0]      year_word;
    logic [DAY_W-1:0] ylen, mlen;

    assign year_word = lunar_word(ROM_AW'(r_k));
    assign ylen      = DAY_W'(year_len(year_word));
    assign mlen      = r_in_leap ? DAY_W'(leap_len(r_word)) : DAY_W'(month_len(r_word, r_m));
    assign out_free  = !r_out_valid || i_out_ready;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_k         = r_k;
        n_m         = r_m;
        n_in_leap   = r_in_leap;
        n_word      = r_word;
        n_res_ok    = r_res_ok;
        n_res_year  = r_res_year;
        n_res_month = r_res_month;
        n_res_day   = r_res_day;
        n_res_leap  = r_res_leap;
        case (r_state)
            S_IDLE: begin
                n_res_ok    = 1'b0;
                n_res_year  = '0;
                n_res_month = '0;
                n_res_day   = '0;
                n_res_leap  = 1'b0;
                if (i_q_valid) begin
                    n_rem = i_q_item.days;
                    n_k   = '0;
                    n_state = i_q_item.ok ? S_YEAR : S_DONE;
                end
            end
            S_YEAR: begin
                if (r_k >= KW'(TABLE_YEARS)) begin
                    n_state = S_DONE;               // past the table end
                end else if (r_rem < ylen) begin
                    n_word    = year_word;
                    n_m       = 4'd1;
                    n_in_leap = 1'b0;
                    n_state   = S_MONTH;
                end else begin
                    n_rem = r_rem - ylen;
                    n_k   = r_k + KW'(1);
                end
            end
            S_MONTH: begin
                if (r_rem < mlen) begin
                    n_res_ok    = 1'b1;
                    n_res_year  = BASE_YEAR + 12'(r_k);
                    n_res_month = r_m;
                    n_res_day   = 5'(r_rem) + 5'd1;
                    n_res_leap  = r_in_leap;
                    n_state     = S_DONE;
                end else begin
                    n_rem = r_rem - mlen;
                    // leap month follows the regular month of the same number
                    if (!r_in_leap && (r_word[3:0] == r_m)) begin
                        n_in_leap = 1'b1;
                    end else if (r_m == 4'd12) begin
                        n_state = S_DONE;           // walked off the year
                    end else begin
                        n_in_leap = 1'b0;
                        n_m       = r_m + 4'd1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_k         <= n_k;
        r_m         <= n_m;
        r_in_leap   <= n_in_leap;
        r_word      <= n_word;
        r_res_ok    <= n_res_ok;
        r_res_year  <= n_res_year;
        r_res_month <= n_res_month;
        r_res_day   <= n_res_day;
        r_res_leap  <= n_res_leap;
        if ((r_state == S_DONE) && out_free) begin
            o_ok            <= r_res_ok;
            o_lun_year      <= r_res_year;
            o_lun_month     <= r_res_month;
            o_lunar_day     <= r_res_day;
            o_is_leap_month <= r_res_leap;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/gregorian_to_lunar_date.sv @@
`timescale 1ns / 1ps
// A date rejected up front goes from the queue straight to S_DONE; a converted one walks
// S_YEAR over the lunar years skipped, then S_MONTH over up to 13 months, before S_DONE.
// The back end's year/month sequencer runs one conversion at a time, and S_DONE waits for
// a free output; the front end and 2-entry queue keep accepting until the queue is full.
// Reset: synchronous active-low; clears queue, sequencer and output valid, and loads
// the year limits with 1999 and 2099.
module gregorian_to_lunar_date #(
    parameter int unsigned TABLE_YEARS = 101
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_greg_year,
    input  logic [3:0]  i_greg_month,
    input  logic [4:0]  i_greg_day,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [11:0] o_lun_year,
    output logic [3:0]  o_lun_month,
    output logic [4:0]  o_lunar_day,
    output logic        o_is_leap_month
);
    import g2l_pkg::*;

    logic [YEAR_W-1:0] r_first_year;
    logic [YEAR_W-1:0] r_last_year;

    logic  push, full, q_valid, pop;
    t_item f_item, q_item;

    // Year limits; an index outside the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_year <= 12'd1999;
            r_last_year  <= 12'd2099;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FIRST_YEAR: r_first_year <= i_cfg_data;
                CFG_LAST_YEAR:  r_last_year  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: validate the date and turn it into a day offset from the lunar base date.
    g2l_front u_front (
        .i_first_year (r_first_year),
        .i_last_year  (r_last_year),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_greg_year  (i_greg_year),
        .i_greg_month (i_greg_month),
        .i_greg_day   (i_greg_day),
        .i_full       (full),
        .o_push       (push),
        .o_item       (f_item)
    );

    // Short queue decouples the combinational front from the sequential year/month walk.
    g2l_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: walk the lunar ROM by years, then by months, and register the result.
    g2l_back #(
        .TABLE_YEARS (TABLE_YEARS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_lun_year      (o_lun_year),
        .o_lun_month     (o_lun_month),
        .o_lunar_day     (o_lunar_day),
        .o_is_leap_month (o_is_leap_month)
    );

endmodule
